// ===== rtl/tcpe_pkg.sv =====
// Shared constants and types for the triggered capture peak energy block.
package tcpe_pkg;

  // Ring store geometry; the depth is a power of two so positions wrap naturally.
  localparam int RING_DEPTH = 2048;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  // Field widths.
  localparam int ACCEL_W = 16;
  localparam int TIME_W  = 48;
  localparam int DUR_W   = 49;
  localparam int CNT_W   = 11;
  localparam int LEN_W   = 12;
  localparam int COOL_W  = 16;
  localparam int POS_W   = 11;
  localparam int PEAK_W  = 32;
  localparam int SQ_W    = 31;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRE_COUNT    = 2'd0,
    CFG_POST_COUNT   = 2'd1,
    CFG_COOLDOWN_LEN = 2'd2
  } cfg_idx_t;

  // Register reset values.
  localparam logic [CNT_W-1:0]  PRE_COUNT_RST    = 11'd1000;
  localparam logic [CNT_W-1:0]  POST_COUNT_RST   = 11'd600;
  localparam logic [COOL_W-1:0] COOLDOWN_LEN_RST = 16'd200;

  // Largest possible sum of three 16-bit squares.
  localparam logic [PEAK_W-1:0] MAX_ENERGY = 32'd3221225472;

endpackage

// ===== rtl/tcpe_if.sv =====
// Valid/ready channel interfaces for the sample input and the event result.
interface tcpe_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [tcpe_pkg::ACCEL_W-1:0]      accel_x;
  logic signed [tcpe_pkg::ACCEL_W-1:0]      accel_y;
  logic signed [tcpe_pkg::ACCEL_W-1:0]      accel_z;
  logic        [tcpe_pkg::TIME_W-1:0]       sample_time_us;
  logic                                     impact_flag;

  modport source (output valid, accel_x, accel_y, accel_z, sample_time_us, impact_flag,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, sample_time_us, impact_flag,
                  output ready);
endinterface

interface tcpe_out_if;
  logic                                     valid;
  logic                                     ready;
  logic        [tcpe_pkg::PEAK_W-1:0]       peak_energy;
  logic signed [tcpe_pkg::DUR_W-1:0]        pre_duration_us;
  logic signed [tcpe_pkg::DUR_W-1:0]        post_duration_us;
  logic signed [tcpe_pkg::DUR_W-1:0]        total_duration_us;
  logic        [tcpe_pkg::POS_W-1:0]        event_position;

  modport source (output valid, peak_energy, pre_duration_us, post_duration_us,
                  total_duration_us, event_position, input ready);
  modport sink   (input valid, peak_energy, pre_duration_us, post_duration_us,
                  total_duration_us, event_position, output ready);
endinterface

// ===== rtl/triggered_capture_peak_energy.sv =====
// Top level: sample ring store, trigger tracking and the sequenced event window walk.
//
//   Channel  | Direction | Handshake     | Contents
//   in_ch    | sink      | valid/ready   | accel_x/y/z, sample_time_us, impact_flag
//   out_ch   | source    | valid/ready   | peak_energy, three durations, event_position
//   cfg_*    | input     | cfg_we only   | pre_count, post_count, cooldown_len
//
// A sample that does not close a window is taken and the block stays ready for the next.
// A sample that closes a window starts a walk over pre_count+post entries, where post is
// post_count with zero counted as one: each window entry is one ring read plus three passes
// through the single squarer, and no sample is taken until the walk ends.
// Reset is synchronous; unwritten ring entries read as zero through the write count,
// so no clearing pass runs after reset.
// A finished result waits in the output register; the next sample is taken meanwhile,
// and a later result waits only if that register is still occupied.
module triggered_capture_peak_energy (
  input  logic                                clk,
  input  logic                                rst_n,
  tcpe_in_if.sink                             in_ch,
  tcpe_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [tcpe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcpe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = tcpe_pkg::RING_AW;
  localparam int SW = 3 * tcpe_pkg::ACCEL_W + tcpe_pkg::TIME_W;

  typedef enum logic [1:0] {
    M_WAIT    = 2'd0,
    M_CAPTURE = 2'd1,
    M_COOL    = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RSTART, S_RIMP, S_RLAST, S_TEND,
    S_RD, S_X, S_Y, S_Z, S_SUM, S_CMP,
    S_D0, S_D1, S_D2, S_OUT
  } state_t;

  // Configuration registers.
  logic [tcpe_pkg::CNT_W-1:0]  pre_r;
  logic [tcpe_pkg::CNT_W-1:0]  post_r;
  logic [tcpe_pkg::COOL_W-1:0] cool_len_r;

  // Trigger tracking state.
  state_t                      state_r;
  mode_t                       mode_r, mode_nxt;
  logic [AW-1:0]               wp_r;
  logic                        wrapped_r;
  logic [AW-1:0]               impact_r, impact_nxt;
  logic [tcpe_pkg::CNT_W-1:0]  post_seen_r, post_seen_nxt;
  logic [tcpe_pkg::COOL_W-1:0] cool_cnt_r, cool_cnt_nxt;
  logic                        done;
  logic [tcpe_pkg::CNT_W-1:0]  post_eff;

  // Walk state.
  logic [AW-1:0]               start_r, last_r, pos_r;
  logic [tcpe_pkg::LEN_W-1:0]  len_r, cnt_r;
  logic [tcpe_pkg::TIME_W-1:0] t0_r, ti_r, te_r;
  logic [tcpe_pkg::SQ_W-1:0]   prod_r;
  logic [tcpe_pkg::PEAK_W-1:0] acc_r, peak_r;
  logic [tcpe_pkg::DUR_W-1:0]  pre_dur_r, post_dur_r, total_dur_r;

  // Ring memory and its registered read.
  logic [SW-1:0]               ring_mem [tcpe_pkg::RING_DEPTH];
  logic [SW-1:0]               ring_q;
  logic                        rd_ok_r;
  logic [AW-1:0]               rd_addr;
  logic                        in_acc;

  // Output register.
  logic                        out_valid_r;
  logic [tcpe_pkg::PEAK_W-1:0] out_peak_r;
  logic [tcpe_pkg::DUR_W-1:0]  out_pre_r, out_post_r, out_total_r;
  logic [tcpe_pkg::POS_W-1:0]  out_pos_r;

  // Shared arithmetic: one squarer and one wide subtractor.
  logic signed [tcpe_pkg::ACCEL_W-1:0]   sq_in;
  logic signed [2*tcpe_pkg::ACCEL_W-1:0] sq_full;
  logic [tcpe_pkg::TIME_W-1:0]           sub_a, sub_b;
  logic [tcpe_pkg::DUR_W-1:0]            sub_res;
  logic [tcpe_pkg::TIME_W-1:0]           rd_time;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign post_eff = (post_r == '0) ? tcpe_pkg::CNT_W'(1) : post_r;

  // Read address follows the sequencer state.
  always_comb begin
    case (state_r)
      S_RSTART: rd_addr = start_r;
      S_RIMP:   rd_addr = impact_r;
      S_RLAST:  rd_addr = last_r;
      default:  rd_addr = pos_r;
    endcase
  end

  // Ring memory: one write per accepted sample, one registered read per cycle.
  // An entry reads as zero until the write pointer has passed it once.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring_mem[wp_r] <= {in_ch.sample_time_us, in_ch.accel_z, in_ch.accel_y, in_ch.accel_x};
    end
    ring_q  <= ring_mem[rd_addr];
    rd_ok_r <= wrapped_r || (rd_addr < wp_r);
  end

  assign rd_time = rd_ok_r ? ring_q[SW-1 -: tcpe_pkg::TIME_W] : '0;

  // Squarer operand follows the axis step.
  always_comb begin
    case (state_r)
      S_X:     sq_in = $signed(ring_q[tcpe_pkg::ACCEL_W-1:0]);
      S_Y:     sq_in = $signed(ring_q[2*tcpe_pkg::ACCEL_W-1 -: tcpe_pkg::ACCEL_W]);
      default: sq_in = $signed(ring_q[3*tcpe_pkg::ACCEL_W-1 -: tcpe_pkg::ACCEL_W]);
    endcase
    if (!rd_ok_r) begin
      sq_in = '0;
    end
  end
  assign sq_full = sq_in * sq_in;

  // Subtractor operands follow the duration step.
  always_comb begin
    case (state_r)
      S_D0: begin
        sub_a = ti_r;
        sub_b = t0_r;
      end
      S_D1: begin
        sub_a = te_r;
        sub_b = ti_r;
      end
      default: begin
        sub_a = te_r;
        sub_b = t0_r;
      end
    endcase
  end
  assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};

  // Trigger, capture and cooldown bookkeeping for the sample on the input.
  always_comb begin
    mode_nxt      = mode_r;
    impact_nxt    = impact_r;
    post_seen_nxt = post_seen_r;
    cool_cnt_nxt  = cool_cnt_r;
    done          = 1'b0;
    case (mode_r)
      M_WAIT: begin
        if (in_ch.impact_flag) begin
          impact_nxt    = wp_r;
          post_seen_nxt = tcpe_pkg::CNT_W'(1);
          if (post_seen_nxt >= post_eff) begin
            done = 1'b1;
          end else begin
            mode_nxt = M_CAPTURE;
          end
        end
      end
      M_CAPTURE: begin
        post_seen_nxt = post_seen_r + tcpe_pkg::CNT_W'(1);
        if (post_seen_nxt >= post_eff) begin
          done = 1'b1;
        end
      end
      default: begin
        if (cool_cnt_r != '1) begin
          cool_cnt_nxt = cool_cnt_r + tcpe_pkg::COOL_W'(1);
        end
        if (cool_cnt_nxt >= cool_len_r) begin
          mode_nxt = M_WAIT;
        end
      end
    endcase
    if (done) begin
      cool_cnt_nxt = '0;
      mode_nxt     = M_COOL;
    end
  end

  // Sequencer, bookkeeping registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_WAIT;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      impact_r    <= '0;
      post_seen_r <= '0;
      cool_cnt_r  <= '0;
      pre_r       <= tcpe_pkg::PRE_COUNT_RST;
      post_r      <= tcpe_pkg::POST_COUNT_RST;
      cool_len_r  <= tcpe_pkg::COOLDOWN_LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        case (cfg_index)
          tcpe_pkg::CFG_PRE_COUNT:    pre_r      <= cfg_wdata[tcpe_pkg::CNT_W-1:0];
          tcpe_pkg::CFG_POST_COUNT:   post_r     <= cfg_wdata[tcpe_pkg::CNT_W-1:0];
          tcpe_pkg::CFG_COOLDOWN_LEN: cool_len_r <= cfg_wdata;
          default: ;
        endcase
      end

      // A drained result clears the register unless S_OUT reloads it in the same cycle.
      if (out_valid_r && out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            wp_r        <= wp_r + AW'(1);
            if (wp_r == '1) begin
              wrapped_r <= 1'b1;
            end
            mode_r      <= mode_nxt;
            impact_r    <= impact_nxt;
            post_seen_r <= post_seen_nxt;
            cool_cnt_r  <= cool_cnt_nxt;
            if (done) begin
              start_r <= impact_nxt - AW'(pre_r);
              len_r   <= tcpe_pkg::LEN_W'(pre_r) + tcpe_pkg::LEN_W'(post_eff);
              state_r <= S_RSTART;
            end
          end
        end
        S_RSTART: begin
          last_r  <= start_r + AW'(len_r - tcpe_pkg::LEN_W'(1));
          state_r <= S_RIMP;
        end
        S_RIMP: begin
          t0_r    <= rd_time;
          state_r <= S_RLAST;
        end
        S_RLAST: begin
          ti_r    <= rd_time;
          state_r <= S_TEND;
        end
        S_TEND: begin
          te_r    <= rd_time;
          pos_r   <= start_r;
          cnt_r   <= len_r;
          peak_r  <= '0;
          state_r <= S_RD;
        end
        S_RD: begin
          state_r <= S_X;
        end
        S_X: begin
          prod_r  <= sq_full[tcpe_pkg::SQ_W-1:0];
          state_r <= S_Y;
        end
        S_Y: begin
          acc_r   <= tcpe_pkg::PEAK_W'(prod_r);
          prod_r  <= sq_full[tcpe_pkg::SQ_W-1:0];
          state_r <= S_Z;
        end
        S_Z: begin
          acc_r   <= acc_r + tcpe_pkg::PEAK_W'(prod_r);
          prod_r  <= sq_full[tcpe_pkg::SQ_W-1:0];
          state_r <= S_SUM;
        end
        S_SUM: begin
          acc_r   <= acc_r + tcpe_pkg::PEAK_W'(prod_r);
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (acc_r > peak_r) begin
            peak_r <= acc_r;
          end
          pos_r <= pos_r + AW'(1);
          cnt_r <= cnt_r - tcpe_pkg::LEN_W'(1);
          if (cnt_r == tcpe_pkg::LEN_W'(1)) begin
            state_r <= S_D0;
          end else begin
            state_r <= S_RD;
          end
        end
        S_D0: begin
          pre_dur_r <= sub_res;
          state_r   <= S_D1;
        end
        S_D1: begin
          post_dur_r <= sub_res;
          state_r    <= S_D2;
        end
        S_D2: begin
          total_dur_r <= sub_res;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          // Load the result once the output register is free.
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_peak_r  <= peak_r;
            out_pre_r   <= pre_dur_r;
            out_post_r  <= post_dur_r;
            out_total_r <= total_dur_r;
            out_pos_r   <= tcpe_pkg::POS_W'(impact_r);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.peak_energy       = out_peak_r;
  assign out_ch.pre_duration_us   = $signed(out_pre_r);
  assign out_ch.post_duration_us  = $signed(out_post_r);
  assign out_ch.total_duration_us = $signed(out_total_r);
  assign out_ch.event_position    = out_pos_r;

  // While a window is being walked the trigger logic must already sit in cooldown.
  a_walk_in_cooldown: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (mode_r == M_COOL))
    else $error("window walk running outside cooldown");

  // The entry counter never runs out before the last entry is compared.
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (cnt_r != '0))
    else $error("walk counter reached zero inside the walk");

  // An accumulated energy never exceeds three full-scale squares.
  a_energy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (acc_r <= tcpe_pkg::MAX_ENERGY))
    else $error("energy sum out of range");

  // A result is loaded only into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ch.ready) |=> (state_r == S_OUT))
    else $error("result loaded over a pending transaction");

endmodule

// ===== test/tb_triggered_capture_peak_energy.sv =====
// Self-checking testbench for the triggered capture peak energy block.
module tb_triggered_capture_peak_energy;
  import tcpe_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int LONG_HOLD     = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 100;
  localparam int RUN_LIMIT     = 200_000_000;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [TIME_W-1:0] STAMP_MAX = '1;

  typedef enum logic [1:0] {
    MODE_WAITING   = 2'd0,
    MODE_CAPTURING = 2'd1,
    MODE_COOLING   = 2'd3
  } capture_mode_t;

  typedef struct packed {
    logic [ACCEL_W-1:0] ax;
    logic [ACCEL_W-1:0] ay;
    logic [ACCEL_W-1:0] az;
    logic [TIME_W-1:0]  t_us;
    logic               impact;
  } sample_txn_t;

  typedef struct packed {
    logic [PEAK_W-1:0] peak;
    logic [DUR_W-1:0]  pre_dur;
    logic [DUR_W-1:0]  post_dur;
    logic [DUR_W-1:0]  total_dur;
    logic [POS_W-1:0]  pos;
  } window_result_t;

  // Mirror of the ring store and trigger tracking, plus the queue of pending event windows.
  class window_scoreboard;
    logic [3*ACCEL_W-1:0] accel_mem [RING_DEPTH];
    logic [TIME_W-1:0]    stamp_mem [RING_DEPTH];
    int unsigned          wr_pos;
    int unsigned          hit_pos;
    int unsigned          cool_count;
    logic [CNT_W-1:0]     post_seen;
    capture_mode_t        mode;
    int unsigned          pre_len;
    int unsigned          post_len;
    int unsigned          cool_len;
    window_result_t       expected_windows [$];
    int unsigned          samples_seen;
    int unsigned          windows_checked;
    int unsigned          mismatches;
    int unsigned          strays;
    int unsigned          reports;

    function new();
      foreach (accel_mem[i]) begin
        accel_mem[i] = '0;
        stamp_mem[i] = '0;
      end
      wr_pos          = 0;
      hit_pos         = 0;
      cool_count      = 0;
      post_seen       = '0;
      mode            = MODE_WAITING;
      pre_len         = PRE_COUNT_RST;
      post_len        = POST_COUNT_RST;
      cool_len        = COOLDOWN_LEN_RST;
      samples_seen    = 0;
      windows_checked = 0;
      mismatches      = 0;
      strays          = 0;
      reports         = 0;
    endfunction

    function void set_config(logic [CFG_DATA_W-1:0] pre, logic [CFG_DATA_W-1:0] post,
                             logic [CFG_DATA_W-1:0] cool);
      pre_len  = pre[CNT_W-1:0];
      post_len = post[CNT_W-1:0];
      cool_len = cool[COOL_W-1:0];
    endfunction

    function int unsigned pending();
      return expected_windows.size();
    endfunction

    function int unsigned failures();
      return mismatches + strays + expected_windows.size();
    endfunction

    // Sum of the three squared axes stored at one ring position.
    function logic [PEAK_W-1:0] energy_at(int unsigned p);
      logic signed [ACCEL_W-1:0] v;
      logic signed [PEAK_W-1:0]  sq;
      logic [PEAK_W-1:0]         sum;
      sum = '0;
      for (int k = 0; k < 3; k++) begin
        v   = accel_mem[p][k*ACCEL_W +: ACCEL_W];
        sq  = v * v;
        sum = sum + sq;
      end
      return sum;
    endfunction

    // Walk the window around the impact and compute the peak and the three durations.
    function window_result_t build_window();
      window_result_t    r;
      int unsigned       post;
      int unsigned       span;
      int unsigned       win_start;
      int unsigned       win_end;
      logic [PEAK_W-1:0] e;
      logic [TIME_W-1:0] t0;
      logic [TIME_W-1:0] ti;
      logic [TIME_W-1:0] te;
      post      = (post_len == 0) ? 1 : post_len;
      span      = pre_len + post;
      win_start = (hit_pos + RING_DEPTH - (pre_len % RING_DEPTH)) % RING_DEPTH;
      win_end   = (win_start + span - 1) % RING_DEPTH;
      r.peak    = '0;
      for (int unsigned i = 0; i < span; i++) begin
        e = energy_at((win_start + i) % RING_DEPTH);
        if (e > r.peak) begin
          r.peak = e;
        end
      end
      t0          = stamp_mem[win_start];
      ti          = stamp_mem[hit_pos % RING_DEPTH];
      te          = stamp_mem[win_end];
      r.pre_dur   = {1'b0, ti} - {1'b0, t0};
      r.post_dur  = {1'b0, te} - {1'b0, ti};
      r.total_dur = {1'b0, te} - {1'b0, t0};
      r.pos       = hit_pos[POS_W-1:0];
      return r;
    endfunction

    // Called for every accepted input transaction.
    function void add_sample(sample_txn_t s);
      int unsigned p;
      int unsigned post;
      bit          done;
      p    = wr_pos % RING_DEPTH;
      post = (post_len == 0) ? 1 : post_len;
      done = 1'b0;
      accel_mem[p] = {s.az, s.ay, s.ax};
      stamp_mem[p] = s.t_us;
      wr_pos       = (p + 1) % RING_DEPTH;
      samples_seen++;
      case (mode)
        MODE_WAITING: begin
          if (s.impact) begin
            hit_pos   = p;
            post_seen = 1;
            if (post_seen >= post) begin
              done = 1'b1;
            end else begin
              mode = MODE_CAPTURING;
            end
          end
        end
        MODE_CAPTURING: begin
          post_seen = post_seen + 1'b1;
          if (post_seen >= post) begin
            done = 1'b1;
          end
        end
        default: begin
          // Impacts are ignored for the whole cooldown, the exit tick included.
          if (cool_count < 32'hFFFF) begin
            cool_count++;
          end
          if (cool_count >= cool_len) begin
            mode = MODE_WAITING;
          end
        end
      endcase
      if (done) begin
        expected_windows.push_back(build_window());
        cool_count = 0;
        mode       = MODE_COOLING;
      end
    endfunction

    // Called for every accepted output transaction.
    function void check_window(window_result_t got);
      window_result_t want;
      if (expected_windows.size() == 0) begin
        strays++;
        reports++;
        if (reports <= REPORT_LIMIT) begin
          $display("unexpected event result: peak %0d position %0d", got.peak, got.pos);
        end
        return;
      end
      want = expected_windows.pop_front();
      windows_checked++;
      if (got.peak !== want.peak || got.pre_dur !== want.pre_dur ||
          got.post_dur !== want.post_dur || got.total_dur !== want.total_dur ||
          got.pos !== want.pos) begin
        mismatches++;
        reports++;
        if (reports <= REPORT_LIMIT) begin
          $display("window %0d mismatch, expected: peak %0d pre %0d post %0d total %0d pos %0d",
                   windows_checked, want.peak, $signed(want.pre_dur), $signed(want.post_dur),
                   $signed(want.total_dur), want.pos);
          $display("window %0d mismatch, actual:   peak %0d pre %0d post %0d total %0d pos %0d",
                   windows_checked, got.peak, $signed(got.pre_dur), $signed(got.post_dur),
                   $signed(got.total_dur), got.pos);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bit                    tx_quiet;
  bit                    rx_quiet;
  bit                    rx_hold;
  bit                    hold_start;
  int unsigned           settings;
  logic [TIME_W-1:0]     stamp_us;

  window_scoreboard sb = new();

  tcpe_in_if  in_ch ();
  tcpe_out_if out_ch ();

  triggered_capture_peak_energy u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Random sample content, biased toward the axis extremes.
  function automatic logic [ACCEL_W-1:0] rand_accel();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return '0;
      default: return ACCEL_W'($urandom);
    endcase
  endfunction

  // Timestamps mostly advance; now and then they jump anywhere in the 48-bit range.
  function automatic logic [TIME_W-1:0] next_stamp();
    if ($urandom_range(0, 15) == 0) begin
      stamp_us = TIME_W'({$urandom, $urandom});
    end else begin
      stamp_us = stamp_us + $urandom_range(0, 20000);
    end
    return stamp_us;
  endfunction

  // Offer one sample after a random gap and hold it until the block accepts it.
  task automatic send_sample(input logic [ACCEL_W-1:0] ax_v, input logic [ACCEL_W-1:0] ay_v,
                             input logic [ACCEL_W-1:0] az_v, input logic [TIME_W-1:0] t_v,
                             input logic imp_v);
    sample_txn_t s;
    int          gap;
    s.ax     = ax_v;
    s.ay     = ay_v;
    s.az     = az_v;
    s.t_us   = t_v;
    s.impact = imp_v;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.accel_x        <= ax_v;
    in_ch.accel_y        <= ay_v;
    in_ch.accel_z        <= az_v;
    in_ch.sample_time_us <= t_v;
    in_ch.impact_flag    <= imp_v;
    do @(posedge clk); while (!in_ch.ready);
    sb.add_sample(s);
  endtask

  task automatic run_random_phase(input int n_items, input int impact_pct);
    repeat (n_items) begin
      send_sample(rand_accel(), rand_accel(), rand_accel(), next_stamp(),
                  $urandom_range(1, 100) <= impact_pct);
    end
  endtask

  // Write all three registers back to back; only called while the block is idle.
  task automatic set_config(input logic [CFG_DATA_W-1:0] pre, input logic [CFG_DATA_W-1:0] post,
                            input logic [CFG_DATA_W-1:0] cool);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PRE_COUNT;
    cfg_wdata <= pre;
    @(posedge clk);
    cfg_index <= CFG_POST_COUNT;
    cfg_wdata <= post;
    @(posedge clk);
    cfg_index <= CFG_COOLDOWN_LEN;
    cfg_wdata <= cool;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(pre, post, cool);
    settings++;
  endtask

  // Stop offering samples until every pending window has come out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: accept output transactions with random gaps and long holds on request.
  initial begin : result_sink
    int             rx_gap;
    window_result_t got;
    rx_gap = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (out_ch.valid && out_ch.ready) begin
          got.peak      = out_ch.peak_energy;
          got.pre_dur   = out_ch.pre_duration_us;
          got.post_dur  = out_ch.post_duration_us;
          got.total_dur = out_ch.total_duration_us;
          got.pos       = out_ch.event_position;
          sb.check_window(got);
          rx_gap = rx_quiet ? 0 : $urandom_range(0, 3);
        end else if (rx_gap > 0) begin
          rx_gap--;
        end
        out_ch.ready <= !rx_hold && (rx_gap == 0);
      end
    end
  end

  // Long receiver stall, counted here so the sender keeps pushing meanwhile.
  initial begin : long_stall
    forever begin
      wait (hold_start);
      hold_start = 1'b0;
      rx_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned pre;
    int unsigned post;
    int unsigned cool;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.accel_x        <= '0;
    in_ch.accel_y        <= '0;
    in_ch.accel_z        <= '0;
    in_ch.sample_time_us <= '0;
    in_ch.impact_flag    <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_PRE_COUNT;
    cfg_wdata            <= '0;
    stamp_us = '0;
    settings = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Widest pre window right after reset: it reaches back into never-written entries.
    // The impact during capture is ignored and the third sample carries the largest energy.
    set_config(1024, 3, 0);
    send_sample(16'h7FFF, 16'h8000, 16'h8000, STAMP_MAX, 1'b0);
    send_sample(16'h0000, 16'h0000, 16'h0000, 48'd0, 1'b1);
    send_sample(16'h8000, 16'h8000, 16'h8000, 48'd5, 1'b1);
    send_sample(16'hFFFF, 16'h0001, 16'h7FFF, 48'd100, 1'b0);
    // Zero cooldown still swallows one tick, so this impact is ignored.
    send_sample(16'h0001, 16'hFFFF, 16'h0000, 48'd200, 1'b1);
    send_sample(16'h1234, 16'hEDCB, 16'h4000, 48'd300, 1'b1);
    send_sample(16'hC000, 16'h3FFF, 16'h0101, 48'd400, 1'b0);
    send_sample(16'h5555, 16'hAAAA, 16'h00FF, 48'd500, 1'b0);
    wait_idle();

    // Zero post count acts as one: impacts complete at once; timestamps wrap backward.
    set_config(2, 0, 2);
    send_sample(16'h0F0F, 16'hF0F0, 16'h7FFF, 48'd600, 1'b1);
    send_sample(16'h8001, 16'h0002, 16'hFFFE, 48'd700, 1'b1);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, STAMP_MAX, 1'b1);
    send_sample(16'h0003, 16'h8000, 16'h0000, STAMP_MAX, 1'b0);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 48'd0, 1'b0);
    send_sample(16'h2000, 16'hE000, 16'h1000, 48'd1, 1'b1);
    wait_idle();

    // Single-sample window with a one-tick cooldown.
    set_config(0, 1, 1);
    send_sample(16'h8000, 16'h0000, 16'h0000, 48'd10, 1'b1);
    send_sample(16'h0000, 16'h8000, 16'h0000, 48'd20, 1'b1);
    send_sample(16'h0000, 16'h0000, 16'h8000, 48'd30, 1'b1);
    send_sample(16'h7FFF, 16'h0000, 16'hFFFF, 48'd40, 1'b1);
    wait_idle();

    // Widest pre window with a long capture, with impacts during capture ignored.
    set_config(1024, 64, 0);
    send_sample(rand_accel(), rand_accel(), rand_accel(), next_stamp(), 1'b1);
    send_sample(rand_accel(), rand_accel(), rand_accel(), next_stamp(), 1'b1);
    run_random_phase(63, 25);
    wait_idle();

    // Back pressure: the result side holds off while impacts keep closing short windows.
    set_config(4, 1, 0);
    hold_start = 1'b1;
    tx_quiet   = 1'b1;
    run_random_phase(16, 100);
    tx_quiet = 1'b0;
    wait_idle();

    // Random settings, mostly short windows; every fourth phase runs without gaps.
    for (int ph = 0; ph < 14; ph++) begin
      pre = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 12);
      case ($urandom_range(0, 7))
        0: post = 0;
        1: post = 1;
        default: post = $urandom_range(1, 8);
      endcase
      cool = $urandom_range(0, 10) + ((pre > 12) ? 10 : 0);
      tx_quiet = (ph % 4 == 3);
      rx_quiet <= (ph % 4 == 3);
      set_config(pre, post, cool);
      run_random_phase($urandom_range(10, 16), 30);
      wait_idle();
    end

    // Longest cooldown: after one event every later impact is ignored.
    tx_quiet = 1'b0;
    rx_quiet <= 1'b0;
    set_config(1024, 1, 65535);
    send_sample(rand_accel(), rand_accel(), rand_accel(), next_stamp(), 1'b1);
    run_random_phase(12, 50);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d samples over %0d register settings, %0d event windows compared",
             sb.samples_seen, settings, sb.windows_checked);
    $display("mismatched windows %0d, results with nothing pending %0d, windows left over %0d",
             sb.mismatches, sb.strays, sb.pending());
    if (sb.failures() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
